// ----- rtl/wrrbs_pkg.sv -----
// shared types and constants of the wave round-robin barrier scheduler
// no dependencies; imported by the interfaces and the top level
package wrrbs_pkg;

  localparam int OP_W     = 3;
  localparam int WAVE_W   = 4;
  localparam int UNIT_F_W = 2;
  localparam int MASK_W   = 16;

  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 3'd0,
    OP_ROUND  = 3'd1,
    OP_PICK   = 3'd2,
    OP_ARRIVE = 3'd3,
    OP_EXIT   = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_UNUSED  = 2'd0,
    ST_ACTIVE  = 2'd1,
    ST_STALLED = 2'd2,
    ST_EXITED  = 2'd3
  } status_e;

  typedef struct packed {
    logic              granted;
    logic [WAVE_W-1:0] granted_wave;
    logic              released;
    logic [MASK_W-1:0] released_mask;
    logic              any_active;
    logic              ignored;
  } result_t;

endpackage

// ----- rtl/wrrbs_if.sv -----
// valid/ready channel interfaces for the scheduler's request and result streams
// depends on wrrbs_pkg for the field widths
interface wrrbs_in_if import wrrbs_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     operation;
  logic [WAVE_W-1:0]   wave;
  logic [UNIT_F_W-1:0] unit;

  modport source (output valid, output operation, output wave, output unit, input ready);
  modport sink   (input valid, input operation, input wave, input unit, output ready);
endinterface

interface wrrbs_out_if import wrrbs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              granted;
  logic [WAVE_W-1:0] granted_wave;
  logic              released;
  logic [MASK_W-1:0] released_mask;
  logic              any_active;
  logic              ignored;

  modport source (output valid, output granted, output granted_wave, output released,
                  output released_mask, output any_active, output ignored, input ready);
  modport sink   (input valid, input granted, input granted_wave, input released,
                  input released_mask, input any_active, input ignored, output ready);
endinterface

// ----- rtl/wrrbs_ram.sv -----
// simple dual-port memory: one write port, one registered read port
// no dependencies; holds the unit lists and the wave generations
module wrrbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- rtl/wave_round_robin_barrier_scheduler.sv -----
// wave scheduler top level: sequencer, wave state, barrier and round-robin pick
// depends on wrrbs_pkg, wrrbs_in_if, wrrbs_out_if and wrrbs_ram
//
// One transaction is worked on at a time and gives exactly one result. Add wave
// and exit pass from acceptance through the execute and finish states to the
// result register. Round start and a taken barrier arrive also pass the release
// check; when the barrier opens, the release walks the wave generation memory
// one wave per cycle through its single read port. A pick examines the unit list
// memory one entry per cycle, at most the unit's wave count of entries. A new
// request is taken while the previous result still waits at the output; a result
// waits in the sequencer only while the output register is still full. No
// clearing pass is needed after reset.
module wave_round_robin_barrier_scheduler import wrrbs_pkg::*; #(
  parameter int WAVES    = 16,
  parameter int UNITS    = 4,
  parameter int GEN_BITS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  wrrbs_in_if.sink     in_i,
  wrrbs_out_if.source  out_o
);

  localparam int SLOT_W   = (WAVES > 1) ? $clog2(WAVES) : 1;
  localparam int LEN_W    = $clog2(WAVES + 1);
  localparam int UNIT_W   = (UNITS > 1) ? $clog2(UNITS) : 1;
  localparam int WIX_W    = (SLOT_W > WAVE_W) ? SLOT_W : WAVE_W;
  localparam int UIX_W    = (UNIT_W > UNIT_F_W) ? UNIT_W : UNIT_F_W;
  localparam int GW_W     = (SLOT_W > WAVE_W) ? SLOT_W : WAVE_W;
  localparam int MX_W     = (WAVES > MASK_W) ? WAVES : MASK_W;
  localparam int LIST_DEPTH = (2 ** UNIT_W) * (2 ** SLOT_W);

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_EXEC     = 6'b000010,
    S_REL_CHK  = 6'b000100,
    S_REL_SCAN = 6'b001000,
    S_PICK     = 6'b010000,
    S_FIN      = 6'b100000
  } state_e;

  // control state
  state_e            state_q, state_d;
  logic              out_valid_q, out_valid_d;
  status_e           status_q [WAVES];
  status_e           status_d [WAVES];
  logic [WAVES-1:0]  waiting_q, waiting_d;
  logic [LEN_W-1:0]  len_q [UNITS];
  logic [LEN_W-1:0]  len_d [UNITS];
  logic [SLOT_W-1:0] ptr_q [UNITS];
  logic [SLOT_W-1:0] ptr_d [UNITS];
  logic [GEN_BITS-1:0] bgen_q, bgen_d;

  // transaction and working registers
  logic [OP_W-1:0]     op_q, op_d;
  logic [WAVE_W-1:0]   w_q, w_d;
  logic [UNIT_F_W-1:0] u_q, u_d;
  logic [SLOT_W-1:0]   idx_q, idx_d;
  logic [SLOT_W-1:0]   pos_q, pos_d;
  logic [SLOT_W-1:0]   cnt_q, cnt_d;
  logic                granted_q, granted_d;
  logic [SLOT_W-1:0]   gwave_q, gwave_d;
  logic                released_q, released_d;
  logic [WAVES-1:0]    mask_q, mask_d;
  logic                ignored_q, ignored_d;
  result_t             out_q, out_d;

  // decoded fields
  logic [WIX_W-1:0]  w_ext;
  logic [SLOT_W-1:0] w_idx;
  logic [UIX_W-1:0]  u_ext;
  logic [UNIT_W-1:0] u_idx;
  logic              w_ok, u_ok, add_ok;
  logic [LEN_W-1:0]  cur_len;
  logic [SLOT_W-1:0] last_pos, pos_next;

  // memories
  logic                     list_we;
  logic [UNIT_W+SLOT_W-1:0] list_waddr, list_raddr;
  logic [SLOT_W-1:0]        list_rdata;
  logic                     gen_we;
  logic [GEN_BITS-1:0]      gen_wdata, gen_rdata;
  logic [SLOT_W-1:0]        gen_raddr;

  // shared scan unit
  logic [SLOT_W-1:0] probe;
  logic              probe_free, hit;
  logic              rel_ok, any_act;
  logic [GW_W-1:0]   gw_ext;
  logic [MX_W-1:0]   mx_ext;

  assign w_ext   = WIX_W'(w_q);
  assign w_idx   = w_ext[SLOT_W-1:0];
  assign u_ext   = UIX_W'(u_q);
  assign u_idx   = u_ext[UNIT_W-1:0];
  assign w_ok    = (32'(w_q) < 32'(WAVES));
  assign u_ok    = (32'(u_q) < 32'(UNITS));
  assign cur_len = len_q[u_idx];
  assign add_ok  = w_ok && u_ok && (status_q[w_idx] == ST_UNUSED)
                   && (cur_len != LEN_W'(WAVES));

  // list position arithmetic wraps at the unit's list length
  assign last_pos = SLOT_W'(cur_len - LEN_W'(1));
  assign pos_next = (pos_q == last_pos) ? '0 : pos_q + SLOT_W'(1);

  assign list_we    = (state_q == S_EXEC) && (op_q == OP_ADD) && add_ok;
  assign list_waddr = {u_idx, SLOT_W'(cur_len)};
  assign list_raddr = (state_q == S_EXEC) ? {u_idx, ptr_q[u_idx]} : {u_idx, pos_next};

  assign gen_we    = (state_q == S_EXEC)
                     && (((op_q == OP_ADD) && add_ok)
                         || ((op_q == OP_ARRIVE) && w_ok && (status_q[w_idx] == ST_ACTIVE)
                             && !waiting_q[w_idx]));
  assign gen_wdata = (op_q == OP_ADD) ? '0 : bgen_q;
  assign gen_raddr = (state_q == S_REL_CHK) ? '0 : idx_q + SLOT_W'(1);

  wrrbs_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (LIST_DEPTH)
  ) u_list_ram (
    .clk_i   (clk_i),
    .we_i    (list_we),
    .waddr_i (list_waddr),
    .wdata_i (w_idx),
    .raddr_i (list_raddr),
    .rdata_o (list_rdata)
  );

  wrrbs_ram #(
    .WIDTH (GEN_BITS),
    .DEPTH (WAVES)
  ) u_gen_ram (
    .clk_i   (clk_i),
    .we_i    (gen_we),
    .waddr_i (w_idx),
    .wdata_i (gen_wdata),
    .raddr_i (gen_raddr),
    .rdata_o (gen_rdata)
  );

  // one probe per cycle: a list entry during pick, a wave during release
  assign probe      = (state_q == S_PICK) ? list_rdata : idx_q;
  assign probe_free = (status_q[probe] == ST_ACTIVE) && !waiting_q[probe];
  assign hit        = (state_q == S_PICK) ? probe_free
                                          : (waiting_q[probe] && (gen_rdata == bgen_q));

  always_comb begin
    logic [WAVES-1:0] live;
    logic             act;
    act = 1'b0;
    for (int i = 0; i < WAVES; i++) begin
      live[i] = (status_q[i] == ST_ACTIVE) || (status_q[i] == ST_STALLED);
      act     = act | (status_q[i] == ST_ACTIVE);
    end
    rel_ok  = (|live) && ((live & ~waiting_q) == '0);
    any_act = act;
  end

  assign gw_ext = GW_W'(gwave_q);
  assign mx_ext = MX_W'(mask_q);

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    status_d    = status_q;
    waiting_d   = waiting_q;
    len_d       = len_q;
    ptr_d       = ptr_q;
    bgen_d      = bgen_q;
    op_d        = op_q;
    w_d         = w_q;
    u_d         = u_q;
    idx_d       = idx_q;
    pos_d       = pos_q;
    cnt_d       = cnt_q;
    granted_d   = granted_q;
    gwave_d     = gwave_q;
    released_d  = released_q;
    mask_d      = mask_q;
    ignored_d   = ignored_q;
    out_d       = out_q;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          op_d       = in_i.operation;
          w_d        = in_i.wave;
          u_d        = in_i.unit;
          granted_d  = 1'b0;
          gwave_d    = '0;
          released_d = 1'b0;
          mask_d     = '0;
          ignored_d  = 1'b0;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_FIN;
        case (op_q)
          OP_ADD: begin
            if (add_ok) begin
              status_d[w_idx]  = ST_ACTIVE;
              waiting_d[w_idx] = 1'b0;
              len_d[u_idx]     = cur_len + LEN_W'(1);
            end else begin
              ignored_d = 1'b1;
            end
          end
          OP_ROUND: begin
            state_d = S_REL_CHK;
          end
          OP_PICK: begin
            if (!u_ok) begin
              ignored_d = 1'b1;
            end else if (cur_len != '0) begin
              pos_d   = ptr_q[u_idx];
              cnt_d   = '0;
              state_d = S_PICK;
            end
          end
          OP_ARRIVE: begin
            if (w_ok && (status_q[w_idx] == ST_ACTIVE) && !waiting_q[w_idx]) begin
              status_d[w_idx]  = ST_STALLED;
              waiting_d[w_idx] = 1'b1;
              state_d          = S_REL_CHK;
            end else begin
              ignored_d = 1'b1;
            end
          end
          OP_EXIT: begin
            if (w_ok && (status_q[w_idx] == ST_ACTIVE)) begin
              status_d[w_idx]  = ST_EXITED;
              waiting_d[w_idx] = 1'b0;
            end else begin
              ignored_d = 1'b1;
            end
          end
          default: begin
            ignored_d = 1'b1;
          end
        endcase
      end
      S_REL_CHK: begin
        if (rel_ok) begin
          idx_d   = '0;
          state_d = S_REL_SCAN;
        end else begin
          state_d = S_FIN;
        end
      end
      S_REL_SCAN: begin
        if (hit) begin
          waiting_d[idx_q] = 1'b0;
          status_d[idx_q]  = ST_ACTIVE;
          mask_d[idx_q]    = 1'b1;
        end
        if (idx_q == SLOT_W'(WAVES - 1)) begin
          bgen_d     = bgen_q + GEN_BITS'(1);
          released_d = 1'b1;
          state_d    = S_FIN;
        end else begin
          idx_d = idx_q + SLOT_W'(1);
        end
      end
      S_PICK: begin
        if (hit) begin
          ptr_d[u_idx] = pos_next;
          granted_d    = 1'b1;
          gwave_d      = list_rdata;
          state_d      = S_FIN;
        end else if (cnt_q == last_pos) begin
          state_d = S_FIN;
        end else begin
          pos_d = pos_next;
          cnt_d = cnt_q + SLOT_W'(1);
        end
      end
      S_FIN: begin
        if (!out_valid_q || out_o.ready) begin
          out_d.granted       = granted_q;
          out_d.granted_wave  = gw_ext[WAVE_W-1:0];
          out_d.released      = released_q;
          out_d.released_mask = mx_ext[MASK_W-1:0];
          out_d.any_active    = any_act;
          out_d.ignored       = ignored_q;
          out_valid_d         = 1'b1;
          state_d             = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      waiting_q   <= '0;
      bgen_q      <= '0;
      for (int i = 0; i < WAVES; i++) begin
        status_q[i] <= ST_UNUSED;
      end
      for (int j = 0; j < UNITS; j++) begin
        len_q[j] <= '0;
        ptr_q[j] <= '0;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      status_q    <= status_d;
      waiting_q   <= waiting_d;
      len_q       <= len_d;
      ptr_q       <= ptr_d;
      bgen_q      <= bgen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    w_q        <= w_d;
    u_q        <= u_d;
    idx_q      <= idx_d;
    pos_q      <= pos_d;
    cnt_q      <= cnt_d;
    granted_q  <= granted_d;
    gwave_q    <= gwave_d;
    released_q <= released_d;
    mask_q     <= mask_d;
    ignored_q  <= ignored_d;
    out_q      <= out_d;
  end

  assign in_i.ready          = (state_q == S_IDLE);
  assign out_o.valid         = out_valid_q;
  assign out_o.granted       = out_q.granted;
  assign out_o.granted_wave  = out_q.granted_wave;
  assign out_o.released      = out_q.released;
  assign out_o.released_mask = out_q.released_mask;
  assign out_o.any_active    = out_q.any_active;
  assign out_o.ignored       = out_q.ignored;

endmodule

// ----- rtl/wrrbs_checker.sv -----
// port-level checks on the scheduler's result stream, bound to the top level
// depends on wave_round_robin_barrier_scheduler for the bind target
module wrrbs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        granted_i,
  input logic [3:0]  granted_wave_i,
  input logic        released_i,
  input logic [15:0] released_mask_i,
  input logic        any_active_i,
  input logic        ignored_i
);

  // a stalled result holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i
      && $stable({granted_i, granted_wave_i, released_i, released_mask_i,
                  any_active_i, ignored_i}))
    else $error("result changed while stalled");

  a_no_grant_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !granted_i |-> granted_wave_i == 4'd0)
    else $error("slot reported without a grant");

  a_mask_only_on_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !released_i |-> released_mask_i == 16'd0)
    else $error("release mask without a release");

  // an ignored transaction neither grants nor opens the barrier
  a_ignored_inert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && ignored_i |-> !granted_i && !released_i)
    else $error("ignored transaction had an effect");

endmodule

bind wave_round_robin_barrier_scheduler wrrbs_checker u_wrrbs_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .granted_i       (out_o.granted),
  .granted_wave_i  (out_o.granted_wave),
  .released_i      (out_o.released),
  .released_mask_i (out_o.released_mask),
  .any_active_i    (out_o.any_active),
  .ignored_i       (out_o.ignored)
);
